/* src/srcp_pkg.sv */
// Shared types, codes and the silencing table for the sound register command player.
// No dependencies.
package srcp_pkg;

	localparam int unsigned CFG_W      = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned NSILENCE   = 36;
	localparam int unsigned IDX_W      = $clog2(NSILENCE + 1);
	localparam int unsigned TDATA_W    = 80;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OP_WRITE = 2'd0,
		CFG_OP_WAIT  = 2'd1,
		CFG_OP_END   = 2'd2,
		CFG_LOOP_EN  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FUNC_START  = 2'd0,
		FUNC_BYTE   = 2'd1,
		FUNC_STOP   = 2'd2,
		FUNC_UNUSED = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		KIND_WRITE   = 3'd0,
		KIND_TIMER   = 3'd1,
		KIND_SEEK    = 3'd2,
		KIND_STOPPED = 3'd3,
		KIND_ERROR   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		TAIL_NONE    = 2'd0,
		TAIL_TIMER   = 2'd1,
		TAIL_STOPPED = 2'd2
	} tail_t;

	localparam logic [3:0] PH_CMD      = 4'd0;
	localparam logic [3:0] PH_WR_OFS   = 4'd1;
	localparam logic [3:0] PH_WR_DATA  = 4'd2;
	localparam logic [3:0] PH_WAIT_0   = 4'd3;
	localparam logic [3:0] PH_WAIT_3   = 4'd6;
	localparam logic [3:0] PH_LOOP_0   = 4'd7;
	localparam logic [3:0] PH_LOOP_3   = 4'd10;

	localparam logic [15:0] RELOAD_MAX = 16'hffff;

	typedef struct packed {
		logic        [7:0]  reg_offset;
		logic        [7:0]  reg_data;
		logic        [15:0] fast_reload;
		logic        [15:0] slow_reload;
		logic        [31:0] seek_offset;
	} payload_t;

	// one job handed from parser to emitter
	typedef struct packed {
		logic     valid;
		logic     run;
		tail_t    tail;
		kind_t    kind;
		payload_t pl;
	} job_t;

	function automatic logic [15:0] silence_entry(input logic [IDX_W-1:0] i);
		logic [15:0] e;
		e = 16'h0000;
		unique case (i)
			6'd0:  e = {8'h84, 8'h00};
			6'd1:  e = {8'h60, 8'h00};
			6'd2:  e = {8'h62, 8'h00};
			6'd3:  e = {8'h63, 8'h00};
			6'd4:  e = {8'h64, 8'h00};
			6'd5:  e = {8'h65, 8'h00};
			6'd6:  e = {8'h68, 8'h00};
			6'd7:  e = {8'h69, 8'h00};
			6'd8:  e = {8'h6c, 8'h00};
			6'd9:  e = {8'h6d, 8'h00};
			6'd10: e = {8'h90, 8'h00};
			6'd11: e = {8'h91, 8'h00};
			6'd12: e = {8'h92, 8'h00};
			6'd13: e = {8'h93, 8'h00};
			6'd14: e = {8'h94, 8'h00};
			6'd15: e = {8'h95, 8'h00};
			6'd16: e = {8'h96, 8'h00};
			6'd17: e = {8'h97, 8'h00};
			6'd18: e = {8'h98, 8'h00};
			6'd19: e = {8'h99, 8'h00};
			6'd20: e = {8'h9a, 8'h00};
			6'd21: e = {8'h9b, 8'h00};
			6'd22: e = {8'h9c, 8'h00};
			6'd23: e = {8'h9d, 8'h00};
			6'd24: e = {8'h9e, 8'h00};
			6'd25: e = {8'h9f, 8'h00};
			6'd26: e = {8'h70, 8'h00};
			6'd27: e = {8'h72, 8'h00};
			6'd28: e = {8'h74, 8'h80};
			6'd29: e = {8'h78, 8'h00};
			6'd30: e = {8'h79, 8'h00};
			6'd31: e = {8'h7c, 8'h00};
			6'd32: e = {8'h7d, 8'h00};
			6'd33: e = {8'h80, 8'h77};
			6'd34: e = {8'h81, 8'hff};
			6'd35: e = {8'h84, 8'h80};
			default: e = 16'h0000;
		endcase
		return e;
	endfunction

endpackage

/* src/srcp_parser.sv */
// Command stream parser: configuration registers, parse state and the job register.
// Depends on srcp_pkg.
module srcp_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [srcp_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [srcp_pkg::CFG_W-1:0]  cfg_wdata,
	input  logic                        accept,
	input  logic [1:0]                  func,
	input  logic [7:0]                  stream_byte,
	input  logic                        take,
	output srcp_pkg::job_t              job_s1
);
	import srcp_pkg::*;

	logic [7:0]  op_write_q, op_wait_q, op_end_q;
	logic        loop_en_q;
	logic        playing_q, playing_d;
	logic [3:0]  phase_q, phase_d;
	logic [7:0]  pend_q, pend_d;
	logic [31:0] asm_q, asm_d, asm_new;
	logic [3:0]  pos_full;
	logic [1:0]  pos;
	job_t        job_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_write_q <= 8'd1;
			op_wait_q  <= 8'd2;
			op_end_q   <= 8'd3;
			loop_en_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_OP_WRITE: op_write_q <= cfg_wdata;
				CFG_OP_WAIT:  op_wait_q  <= cfg_wdata;
				CFG_OP_END:   op_end_q   <= cfg_wdata;
				CFG_LOOP_EN:  loop_en_q  <= cfg_wdata[0];
			endcase
		end
	end

	// wait and loop phases both map onto byte positions 0..3
	assign pos_full = phase_q - PH_WAIT_0;
	assign pos      = pos_full[1:0];
	assign asm_new  = asm_q | ({24'd0, stream_byte} << {pos, 3'b000});

	always_comb begin
		playing_d = playing_q;
		phase_d   = phase_q;
		pend_d    = pend_q;
		asm_d     = asm_q;
		job_d     = '0;
		job_d.kind = KIND_WRITE;
		job_d.tail = TAIL_NONE;
		unique case (func_t'(func))
			FUNC_START: begin
				playing_d = 1'b1;
				phase_d   = PH_CMD;
				pend_d    = 8'd0;
				asm_d     = 32'd0;
				job_d.valid = 1'b1;
				job_d.run   = 1'b1;
				job_d.tail  = TAIL_TIMER;
			end
			FUNC_STOP: begin
				playing_d = 1'b0;
				phase_d   = PH_CMD;
				pend_d    = 8'd0;
				asm_d     = 32'd0;
				job_d.valid = 1'b1;
				job_d.run   = 1'b1;
			end
			FUNC_BYTE: begin
				if (playing_q) begin
					if (phase_q == PH_WR_OFS) begin
						pend_d  = stream_byte;
						phase_d = PH_WR_DATA;
					end else if (phase_q == PH_WR_DATA) begin
						job_d.valid         = 1'b1;
						job_d.pl.reg_offset = pend_q;
						job_d.pl.reg_data   = stream_byte;
						phase_d = PH_CMD;
					end else if (phase_q >= PH_WAIT_0 && phase_q <= PH_LOOP_3) begin
						if (pos != 2'd3) begin
							asm_d   = asm_new;
							phase_d = phase_q + 4'd1;
						end else begin
							job_d.valid = 1'b1;
							if (phase_q == PH_WAIT_3) begin
								job_d.kind           = KIND_TIMER;
								job_d.pl.fast_reload = asm_new[15:0];
								job_d.pl.slow_reload = asm_new[31:16];
							end else begin
								job_d.kind           = KIND_SEEK;
								job_d.pl.seek_offset = asm_new;
							end
							asm_d   = 32'd0;
							phase_d = PH_CMD;
						end
					end else begin
						phase_d = PH_CMD;
						asm_d   = 32'd0;
						priority if (stream_byte == op_write_q) begin
							phase_d = PH_WR_OFS;
						end else if (stream_byte == op_wait_q) begin
							phase_d = PH_WAIT_0;
						end else if (stream_byte == op_end_q) begin
							if (loop_en_q) begin
								phase_d = PH_LOOP_0;
							end else begin
								playing_d   = 1'b0;
								pend_d      = 8'd0;
								job_d.valid = 1'b1;
								job_d.run   = 1'b1;
								job_d.tail  = TAIL_STOPPED;
							end
						end else begin
							job_d.valid = 1'b1;
							job_d.kind  = KIND_ERROR;
						end
					end
				end
			end
			FUNC_UNUSED: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0;
			phase_q   <= PH_CMD;
			pend_q    <= 8'd0;
			asm_q     <= 32'd0;
			job_s1    <= '0;
		end else begin
			if (accept) begin
				playing_q <= playing_d;
				phase_q   <= phase_d;
				pend_q    <= pend_d;
				asm_q     <= asm_d;
			end
			if (accept && job_d.valid) begin
				job_s1 <= job_d;
			end else if (take) begin
				job_s1.valid <= 1'b0;
			end
		end
	end

endmodule

/* src/srcp_emitter.sv */
// Result sequencer: walks silencing runs and drives the output register.
// Depends on srcp_pkg.
module srcp_emitter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srcp_pkg::job_t       job_s1,
	output logic                 take,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [srcp_pkg::TDATA_W-1:0] m_tdata,
	output logic [2:0]           m_tuser,
	output logic                 m_tlast
);
	import srcp_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             load;
	logic             in_table;
	logic [15:0]      ent;
	payload_t         pl_d, pl_q;
	kind_t            kind_d, kind_q;
	logic             last_d, last_q;

	assign load     = job_s1.valid && (!m_tvalid || m_tready);
	assign in_table = idx_q < IDX_W'(NSILENCE);
	assign ent      = silence_entry(idx_q);

	always_comb begin
		pl_d   = '0;
		kind_d = KIND_WRITE;
		last_d = 1'b1;
		take   = 1'b0;
		if (!job_s1.run) begin
			pl_d   = job_s1.pl;
			kind_d = job_s1.kind;
			take   = load;
		end else if (in_table) begin
			pl_d.reg_offset = ent[15:8];
			pl_d.reg_data   = ent[7:0];
			last_d = (job_s1.tail == TAIL_NONE) && (idx_q == IDX_W'(NSILENCE - 1));
			take   = load && last_d;
		end else begin
			if (job_s1.tail == TAIL_TIMER) begin
				kind_d = KIND_TIMER;
				pl_d.fast_reload = RELOAD_MAX;
				pl_d.slow_reload = RELOAD_MAX;
			end else begin
				kind_d = KIND_STOPPED;
			end
			take = load;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid <= 1'b1;
				if (job_s1.run) idx_q <= take ? '0 : idx_q + IDX_W'(1);
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pl_q   <= pl_d;
			kind_q <= kind_d;
			last_q <= last_d;
		end
	end

	assign m_tdata = {pl_q.seek_offset, pl_q.slow_reload, pl_q.fast_reload,
	                  pl_q.reg_data, pl_q.reg_offset};
	assign m_tuser = kind_q;
	assign m_tlast = last_q;

endmodule

/* src/sound_register_command_player.sv */
// Sound register command player top level: parser feeding the result sequencer.
// An accepted word passes through the job register, then the output register.
// Throughput: one input word and one result word per cycle while m_tready is high;
// start, stop and a non-looping end hold s_tready low while the silencing run drains.
// Reset: arst_n clears parse state, playback and output valid; opcodes go to 1, 2, 3.
// Depends on srcp_pkg, srcp_parser, srcp_emitter.
module sound_register_command_player (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [srcp_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [srcp_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] stream_byte
	input  logic [1:0]  s_tuser,   // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [srcp_pkg::TDATA_W-1:0] m_tdata, // [7:0] reg_offset, [15:8] reg_data,
	                                              // [31:16] fast_reload, [47:32] slow_reload,
	                                              // [79:48] seek_offset
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast
);
	import srcp_pkg::*;

	job_t job_s1;
	logic take;
	logic accept;

	assign s_tready = !job_s1.valid || take;
	assign accept   = s_tvalid && s_tready;

	srcp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.func        (s_tuser),
		.stream_byte (s_tdata),
		.take        (take),
		.job_s1      (job_s1)
	);

	srcp_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_s1   (job_s1),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* src/srcp_checker.sv */
// Port-level checks for the sound register command player, bound to the top level.
// Depends on srcp_pkg.
module srcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [srcp_pkg::TDATA_W-1:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);
	import srcp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= KIND_ERROR)
		else $error("kind out of range");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_WRITE |-> m_tlast)
		else $error("non-write result without last mark");

	a_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_WRITE |-> m_tdata[TDATA_W-1:16] == '0)
		else $error("register write carries timer or seek bits");

endmodule

bind sound_register_command_player srcp_checker u_srcp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
